@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_RST(lbl, clkx, rstx, prop, msg) \
    lbl: assert property (@(posedge clkx) disable iff (!rstx) prop) else $error(msg);

// checked at every edge
`define ASSERT_ALWAYS(lbl, clkx, prop, msg) \
    lbl: assert property (@(posedge clkx) prop) else $error(msg);

`endif

@@ hw/rtl/pfrt_pkg.sv @@
// ----------------------------------------------------------------------------
// pfrt_pkg
// Types and constants of the per-owner frequency residency tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfrt_pkg;

    localparam int DEF_MAX_OWNERS    = 256;
    localparam int DEF_NUM_FREQS     = 64;
    localparam int DEF_FREQ_STEP_MHZ = 50;

    localparam logic [31:0] KHZ_PER_MHZ = 32'd1000;
    localparam logic [39:0] GAP_RESET   = 40'd1000000000;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OOO   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_ZERO  = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV1,
        S_SCAN,
        S_META,
        S_BKT,
        S_GAP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic [63:0] last_end;
        logic [31:0] errors;
    } meta_t;

endpackage

@@ hw/rtl/pfrt_div.sv @@
// ----------------------------------------------------------------------------
// pfrt_div
// Bucket index from a kHz frequency: two pipelined reciprocal multiplications
// (kHz to MHz, then MHz to steps) with rounding and clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfrt_div
    import pfrt_pkg::*;
#(
    parameter int NUM_FREQS     = DEF_NUM_FREQS,
    parameter int FREQ_STEP_MHZ = DEF_FREQ_STEP_MHZ
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  div_req_t   req,
    output logic       done,
    output logic [7:0] bucket
);

    // ceil(2^38 / 1000), exact for every 32-bit dividend
    localparam logic [31:0] KHZ_RECIP  = 32'h10624DD3;
    localparam logic [31:0] HALF_STEP  = 32'(FREQ_STEP_MHZ / 2);
    localparam logic [31:0] TOP        = 32'(NUM_FREQS * FREQ_STEP_MHZ);
    localparam logic [7:0]  TOP_BKT    = 8'(NUM_FREQS - 1);
    // ceil(2^29 / step), exact below 2^18
    localparam logic [29:0] STEP_RECIP =
        30'(((64'd1 << 29) + 64'(FREQ_STEP_MHZ) - 64'd1) / 64'(FREQ_STEP_MHZ));

    logic        v1_reg;
    logic        done_reg;
    logic [22:0] mhz_reg, mhz_next;
    logic [7:0]  bkt_reg, bkt_next;
    logic [63:0] khz_prod;
    logic [31:0] rnd;
    logic [47:0] step_prod;

    always_comb
    begin
        khz_prod  = {32'd0, req.dividend} * {32'd0, KHZ_RECIP};
        mhz_next  = khz_prod[60:38];
        rnd       = {9'd0, mhz_reg} + HALF_STEP;
        step_prod = {30'd0, rnd[17:0]} * {18'd0, STEP_RECIP};
        if (rnd >= TOP)
            bkt_next = TOP_BKT;
        else if (step_prod[36:29] == 8'd0)
            bkt_next = 8'd1;
        else
            bkt_next = step_prod[36:29];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
            mhz_reg <= mhz_next;
        if (v1_reg)
            bkt_reg <= bkt_next;
    end

    assign done   = done_reg;
    assign bucket = bkt_reg;

endmodule

@@ hw/rtl/per_id_frequency_residency_tracker.sv @@
// ----------------------------------------------------------------------------
// per_id_frequency_residency_tracker
// Per-owner table of frequency residency buckets, gap time and error counts.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat
//  in      | in_valid / in_ready  | owner_id, freq_khz, period_start, period_end
//  out     | out_valid / out_ready| status .. entries_used
//  cfg     | cfg_wen              | cfg_wdata (gap limit, ns)
//
//  A beat is taken only in the idle state, so no new beat is accepted until the
//  one before has left for the output register: the bucket index from two
//  pipelined reciprocal multiplications, a linear tag scan of one slot per cycle,
//  then metadata, bucket and gap read-modify-write, as the beat needs them, and the result.
//  After reset the bucket memory, MAX_OWNERS * 2^ceil(log2 NUM_FREQS) words
//  (16384 by default), is zeroed; no input beat is taken until then.
//  A finished result waits in the output register; the next beat is taken
//  meanwhile and stalls only at its own result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module per_id_frequency_residency_tracker
    import pfrt_pkg::*;
#(
    parameter int MAX_OWNERS    = DEF_MAX_OWNERS,
    parameter int NUM_FREQS     = DEF_NUM_FREQS,
    parameter int FREQ_STEP_MHZ = DEF_FREQ_STEP_MHZ
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [39:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] owner_id,
    input  logic [31:0] freq_khz,
    input  logic [63:0] period_start,
    input  logic [63:0] period_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  entry_slot,
    output logic [5:0]  bucket_index,
    output logic [63:0] bucket_total,
    output logic [39:0] gap_added,
    output logic [31:0] error_total,
    output logic [8:0]  entries_used
);

    localparam int OW        = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int FW        = $clog2(NUM_FREQS);
    localparam int BAW       = OW + FW;
    localparam int BKT_DEPTH = MAX_OWNERS * (1 << FW);

    state_t state_reg, state_next;

    logic [39:0] gap_lim_reg;
    logic [31:0] owner_reg, owner_next;
    logic [31:0] freq_reg, freq_next;
    logic [63:0] start_reg, start_next;
    logic [63:0] end_reg, end_next;
    logic [FW-1:0] bucket_reg, bucket_next;
    logic [OW:0]   scan_cnt_reg, scan_cnt_next;
    logic          cmp_v_reg, cmp_v_next;
    logic [OW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          found_reg, found_next;
    logic          free_v_reg, free_v_next;
    logic [OW-1:0] slot_reg, slot_next;
    logic [OW-1:0] free_reg, free_next;
    logic          new_reg, new_next;
    logic [31:0]   err_reg, err_next;
    logic [63:0]   last_reg, last_next;
    logic [39:0]   gap_reg, gap_next;
    logic [BAW:0]  clr_cnt_reg, clr_cnt_next;
    logic [OW:0]   ent_cnt_reg, ent_cnt_next;

    status_t       res_status_reg, res_status_next;
    logic [OW-1:0] res_slot_reg, res_slot_next;
    logic [FW-1:0] res_bucket_reg, res_bucket_next;
    logic [63:0]   res_total_reg, res_total_next;
    logic [39:0]   res_gap_reg, res_gap_next;
    logic [31:0]   res_err_reg, res_err_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [7:0]    out_slot_reg, out_slot_next;
    logic [5:0]    out_bucket_reg, out_bucket_next;
    logic [63:0]   out_total_reg, out_total_next;
    logic [39:0]   out_gap_reg, out_gap_next;
    logic [31:0]   out_err_reg, out_err_next;
    logic [8:0]    out_used_reg, out_used_next;

    // memories
    logic [31:0]   tag_mem [MAX_OWNERS];
    logic          tag_we;
    logic [OW-1:0] tag_waddr, tag_raddr;
    logic [31:0]   tag_q;

    meta_t         meta_mem [MAX_OWNERS];
    logic          meta_we;
    logic [OW-1:0] meta_addr;
    meta_t         meta_wdata, meta_q;

    logic [63:0]   bkt_mem [BKT_DEPTH];
    logic          bkt_we;
    logic [BAW-1:0] bkt_waddr, bkt_raddr;
    logic [63:0]   bkt_wdata, bkt_q;

    div_req_t      div_req;
    logic          div_done;
    logic [7:0]    div_bkt;

    logic [63:0]   dur, gap_full, new_total;
    logic [31:0]   slot_wide, bucket_wide, used_wide;
    logic          in_acc;

    pfrt_div #(
        .NUM_FREQS     (NUM_FREQS),
        .FREQ_STEP_MHZ (FREQ_STEP_MHZ)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .done   (div_done),
        .bucket (div_bkt)
    );

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= owner_reg;
        tag_q <= tag_mem[tag_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_addr] <= meta_wdata;
        meta_q <= meta_mem[meta_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_waddr] <= bkt_wdata;
        bkt_q <= bkt_mem[bkt_raddr];
    end

    assign in_acc    = in_valid && in_ready;
    assign dur       = end_reg - start_reg;
    assign gap_full  = start_reg - last_reg;
    assign new_total = bkt_q + dur;

    always_comb
    begin
        state_next      = state_reg;
        owner_next      = owner_reg;
        freq_next       = freq_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        bucket_next     = bucket_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_v_next      = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        free_v_next     = free_v_reg;
        slot_next       = slot_reg;
        free_next       = free_reg;
        new_next        = new_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        gap_next        = gap_reg;
        clr_cnt_next    = clr_cnt_reg;
        ent_cnt_next    = ent_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_bucket_next = res_bucket_reg;
        res_total_next  = res_total_reg;
        res_gap_next    = res_gap_reg;
        res_err_next    = res_err_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_bucket_next = out_bucket_reg;
        out_total_next  = out_total_reg;
        out_gap_next    = out_gap_reg;
        out_err_next    = out_err_reg;
        out_used_next   = out_used_reg;

        tag_we     = 1'b0;
        tag_waddr  = slot_reg;
        tag_raddr  = scan_cnt_reg[OW-1:0];
        meta_we    = 1'b0;
        meta_addr  = slot_reg;
        meta_wdata = '{last_end: last_reg, errors: err_reg};
        bkt_we     = 1'b0;
        bkt_waddr  = {slot_reg, bucket_reg};
        bkt_raddr  = {slot_reg, bucket_reg};
        bkt_wdata  = new_total;
        div_req    = '{start: 1'b0, dividend: freq_khz};
        in_ready   = 1'b0;

        slot_wide   = 32'(res_slot_reg);
        bucket_wide = 32'(res_bucket_reg);
        used_wide   = 32'(ent_cnt_reg);

        case (state_reg)
            S_CLEAR:
            begin
                bkt_we       = 1'b1;
                bkt_waddr    = clr_cnt_reg[BAW-1:0];
                bkt_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (BAW + 1)'(BKT_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    owner_next    = owner_id;
                    freq_next     = freq_khz;
                    start_next    = period_start;
                    end_next      = period_end;
                    div_req.start = 1'b1;
                    state_next    = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    bucket_next   = div_bkt[FW-1:0];
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    free_v_next   = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg != (OW + 1)'(MAX_OWNERS))
                begin
                    cmp_v_next    = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[OW-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (cmp_v_reg)
                begin
                    // slots fill from the bottom and are never freed
                    if ({1'b0, cmp_idx_reg} < ent_cnt_reg)
                    begin
                        if (!found_reg && tag_q == owner_reg)
                        begin
                            found_next = 1'b1;
                            slot_next  = cmp_idx_reg;
                        end
                    end
                    else if (!free_v_reg)
                    begin
                        free_v_next = 1'b1;
                        free_next   = cmp_idx_reg;
                    end
                end
                else if (scan_cnt_reg == (OW + 1)'(MAX_OWNERS))
                begin
                    if (found_reg)
                    begin
                        new_next   = 1'b0;
                        meta_addr  = slot_reg;
                        state_next = S_META;
                    end
                    else if (free_v_reg)
                    begin
                        slot_next             = free_reg;
                        new_next              = 1'b1;
                        tag_we                = 1'b1;
                        tag_waddr             = free_reg;
                        ent_cnt_next          = ent_cnt_reg + 1'b1;
                        meta_addr             = free_reg;
                        state_next            = S_META;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        res_bucket_next = '0;
                        res_total_next  = '0;
                        res_gap_next    = '0;
                        res_err_next    = '0;
                        state_next      = S_OUT;
                    end
                end
            end
            S_META:
            begin
                err_next  = new_reg ? 32'd0 : meta_q.errors;
                last_next = new_reg ? 64'd0 : meta_q.last_end;
                res_slot_next   = slot_reg;
                res_bucket_next = '0;
                res_total_next  = '0;
                res_gap_next    = '0;
                if (start_reg >= end_reg || freq_reg == 32'd0)
                begin
                    meta_we         = 1'b1;
                    meta_wdata      = '{last_end: last_next, errors: err_next + 32'd1};
                    res_err_next    = err_next + 32'd1;
                    res_status_next = (start_reg >= end_reg) ? ST_EMPTY : ST_ZERO;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_BKT;
                end
            end
            S_BKT:
            begin
                bkt_we          = 1'b1;
                res_bucket_next = bucket_reg;
                res_total_next  = new_total;
                meta_we         = 1'b1;
                if (last_reg > start_reg)
                begin
                    meta_wdata      = '{last_end: last_reg, errors: err_reg + 32'd1};
                    res_err_next    = err_reg + 32'd1;
                    res_status_next = ST_OOO;
                    state_next      = S_OUT;
                end
                else
                begin
                    meta_wdata      = '{last_end: end_reg, errors: err_reg};
                    res_err_next    = err_reg;
                    res_status_next = ST_OK;
                    if (gap_full != 64'd0 && gap_full < {24'd0, gap_lim_reg})
                    begin
                        gap_next   = gap_full[39:0];
                        bkt_raddr  = {slot_reg, FW'(0)};
                        state_next = S_GAP;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_GAP:
            begin
                bkt_we       = 1'b1;
                bkt_waddr    = {slot_reg, FW'(0)};
                bkt_wdata    = bkt_q + {24'd0, gap_reg};
                res_gap_next = gap_reg;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = slot_wide[7:0];
                    out_bucket_next = bucket_wide[5:0];
                    out_total_next  = res_total_reg;
                    out_gap_next    = res_gap_reg;
                    out_err_next    = res_err_reg;
                    out_used_next   = used_wide[8:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            gap_lim_reg   <= GAP_RESET;
            clr_cnt_reg   <= '0;
            ent_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cmp_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wen)
                gap_lim_reg <= cfg_wdata;
            clr_cnt_reg   <= clr_cnt_next;
            ent_cnt_reg   <= ent_cnt_next;
            out_valid_reg <= out_valid_next;
            cmp_v_reg     <= cmp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg      <= owner_next;
        freq_reg       <= freq_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        bucket_reg     <= bucket_next;
        scan_cnt_reg   <= scan_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        free_v_reg     <= free_v_next;
        slot_reg       <= slot_next;
        free_reg       <= free_next;
        new_reg        <= new_next;
        err_reg        <= err_next;
        last_reg       <= last_next;
        gap_reg        <= gap_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_bucket_reg <= res_bucket_next;
        res_total_reg  <= res_total_next;
        res_gap_reg    <= res_gap_next;
        res_err_reg    <= res_err_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_bucket_reg <= out_bucket_next;
        out_total_reg  <= out_total_next;
        out_gap_reg    <= out_gap_next;
        out_err_reg    <= out_err_next;
        out_used_reg   <= out_used_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign entry_slot   = out_slot_reg;
    assign bucket_index = out_bucket_reg;
    assign bucket_total = out_total_reg;
    assign gap_added    = out_gap_reg;
    assign error_total  = out_err_reg;
    assign entries_used = out_used_reg;

    `ASSERT_RST(a_cnt_bound, clk, rst_n, ent_cnt_reg <= (OW + 1)'(MAX_OWNERS), "count overflow")
    `ASSERT_RST(a_out_hold, clk, rst_n, out_valid_reg && !out_ready |=> out_valid_reg, "beat lost")
    `ASSERT_RST(a_one_beat, clk, rst_n, in_acc |=> !in_ready, "second beat taken while busy")

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-owner frequency residency tracker: a short
// table of directed work periods, then random period streams per owner under
// several gap limits, each result checked field by field against the table's
// expected values or a local model of the owner table and bucket store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pfrt_pkg::*;

    localparam int OWNERS = DEF_MAX_OWNERS;
    localparam int FREQS  = DEF_NUM_FREQS;
    localparam int STEP   = DEF_FREQ_STEP_MHZ;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct {
        status_t     st;
        logic [7:0]  slot;
        logic [5:0]  bkt;
        logic [63:0] total;
        logic [39:0] gap;
        logic [31:0] errs;
        logic [8:0]  used;
    } residency_t;

    typedef struct {
        logic [31:0] owner;
        logic [31:0] freq;
        logic [63:0] t_start;
        logic [63:0] t_end;
        bit          typed;
        residency_t  want;
    } period_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [39:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] owner_id = '0;
    logic [31:0] freq_khz = '0;
    logic [63:0] period_start = '0;
    logic [63:0] period_end = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  entry_slot;
    logic [5:0]  bucket_index;
    logic [63:0] bucket_total;
    logic [39:0] gap_added;
    logic [31:0] error_total;
    logic [8:0]  entries_used;

    per_id_frequency_residency_tracker uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .owner_id(owner_id), .freq_khz(freq_khz),
        .period_start(period_start), .period_end(period_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .entry_slot(entry_slot), .bucket_index(bucket_index),
        .bucket_total(bucket_total), .gap_added(gap_added),
        .error_total(error_total), .entries_used(entries_used)
    );

    // model state
    logic [39:0] m_gap_limit;
    logic [31:0] m_tags [OWNERS];
    bit          m_valid [OWNERS];
    logic [63:0] m_last_end [OWNERS];
    logic [31:0] m_errs [OWNERS];
    logic [63:0] m_buckets [OWNERS*FREQS];
    logic [8:0]  m_used;

    residency_t  pending_q [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    int          out_stall = 0;

    logic [31:0] owner_pool [$];
    logic [63:0] owner_clock [logic [31:0]];
    period_row_t directed [$];

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic residency_t track_period(logic [31:0] owner, logic [31:0] freq,
                                                logic [63:0] ts, logic [63:0] te);
        residency_t  r;
        int          slot;
        int          free_slot;
        int          b;
        logic [63:0] g;
        r = '{ST_OK, 8'd0, 6'd0, 64'd0, 40'd0, 32'd0, 9'd0};
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < OWNERS; i++)
        begin
            if (m_valid[i])
            begin
                if (slot < 0 && m_tags[i] == owner)
                    slot = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (slot < 0)
        begin
            if (free_slot < 0)
            begin
                r.st = ST_FULL;
                r.used = m_used;
                return r;
            end
            slot = free_slot;
            m_valid[slot] = 1'b1;
            m_tags[slot] = owner;
            m_last_end[slot] = '0;
            m_errs[slot] = '0;
            for (int k = 0; k < FREQS; k++)
                m_buckets[slot*FREQS + k] = '0;
            m_used++;
        end
        r.slot = slot[7:0];
        r.used = m_used;
        if (ts >= te)
        begin
            m_errs[slot]++;
            r.st = ST_EMPTY;
            r.errs = m_errs[slot];
            return r;
        end
        if (freq == 0)
        begin
            m_errs[slot]++;
            r.st = ST_ZERO;
            r.errs = m_errs[slot];
            return r;
        end
        b = int'((freq / KHZ_PER_MHZ + STEP/2) / STEP);
        if (b >= FREQS)
            b = FREQS - 1;
        if (b == 0)
            b = 1;
        m_buckets[slot*FREQS + b] += te - ts;
        r.bkt = b[5:0];
        r.total = m_buckets[slot*FREQS + b];
        if (m_last_end[slot] > ts)
        begin
            m_errs[slot]++;
            r.st = ST_OOO;
        end
        else
        begin
            g = ts - m_last_end[slot];
            m_last_end[slot] = te;
            if (g > 0 && g < {24'd0, m_gap_limit})
            begin
                m_buckets[slot*FREQS] += g;
                r.gap = g[39:0];
            end
        end
        r.errs = m_errs[slot];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h", field, got, want);
        fail_count++;
    endtask

    always @(negedge clk)
    begin
        residency_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected beat", 64'd0, 64'd0);
            else
            begin
                w = pending_q.pop_front();
                if (status !== w.st)
                    report_mismatch("status", 64'(status), 64'(w.st));
                if (entry_slot !== w.slot)
                    report_mismatch("entry_slot", 64'(entry_slot), 64'(w.slot));
                if (bucket_index !== w.bkt)
                    report_mismatch("bucket_index", 64'(bucket_index), 64'(w.bkt));
                if (bucket_total !== w.total)
                    report_mismatch("bucket_total", bucket_total, w.total);
                if (gap_added !== w.gap)
                    report_mismatch("gap_added", 64'(gap_added), 64'(w.gap));
                if (error_total !== w.errs)
                    report_mismatch("error_total", 64'(error_total), 64'(w.errs));
                if (entries_used !== w.used)
                    report_mismatch("entries_used", 64'(entries_used), 64'(w.used));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            out_stall <= $urandom_range(0, 8);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_period(logic [31:0] owner, logic [31:0] freq,
                               logic [63:0] ts, logic [63:0] te,
                               bit typed, residency_t want);
        residency_t got;
        int         idle;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            idle = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        owner_id <= owner;
        freq_khz <= freq;
        period_start <= ts;
        period_end <= te;
        do @(negedge clk); while (!in_ready);
        got = track_period(owner, freq, ts, te);
        pending_q.push_back(typed ? want : got);
        @(posedge clk);
    endtask

    task automatic drain_and_set_limit(logic [39:0] limit);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_wen <= 1'b0;
        m_gap_limit = limit;
        @(posedge clk);
    endtask

    task automatic random_periods(int count);
        logic [31:0] owner;
        logic [31:0] freq;
        logic [63:0] t;
        logic [63:0] ts;
        logic [63:0] te;
        logic [63:0] dur;
        int          kind;
        residency_t  none;
        none = '{ST_OK, 8'd0, 6'd0, 64'd0, 40'd0, 32'd0, 9'd0};
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 40)
                owner = $urandom;
            else
                owner = owner_pool[$urandom_range(0, owner_pool.size() - 1)];
            t = owner_clock.exists(owner) ? owner_clock[owner] : 64'd0;
            freq = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 3300000);
            case ($urandom_range(0, 3))
                0: dur = 64'($urandom_range(1, 20));
                1: dur = 64'($urandom_range(1, 2000000));
                2: dur = {32'd0, $urandom};
                default: dur = {24'd0, 8'($urandom_range(0, 255)), $urandom};
            endcase
            if (dur == 0)
                dur = 1;
            case ($urandom_range(0, 4))
                0: ts = t;
                1: ts = t + 64'($urandom_range(1, 5000));
                2: ts = t + 64'($urandom_range(1, 2000000000));
                3: ts = t + {23'd0, 9'($urandom_range(0, 511)), $urandom};
                default: ts = t + 64'($urandom_range(1, 1000));
            endcase
            te = ts + dur;
            kind = $urandom_range(0, 99);
            if (kind < 72)
                owner_clock[owner] = te;
            else if (kind < 80)
                te = ts - 64'($urandom_range(0, 5));
            else if (kind < 86)
                freq = 0;
            else if (kind < 93)
            begin
                ts = (t > 64'd10) ? t - 64'($urandom_range(1, 10)) : t;
                te = ts + dur;
            end
            else
            begin
                ts = {$urandom, $urandom};
                te = {$urandom, $urandom};
            end
            send_period(owner, freq, ts, te, 1'b0, none);
        end
    endtask

    initial
    begin
        period_row_t row;
        residency_t  none;
        none = '{ST_OK, 8'd0, 6'd0, 64'd0, 40'd0, 32'd0, 9'd0};
        m_gap_limit = GAP_RESET;
        m_used = '0;
        for (int i = 0; i < OWNERS; i++)
        begin
            m_tags[i] = '0;
            m_valid[i] = 1'b0;
            m_last_end[i] = '0;
            m_errs[i] = '0;
        end
        for (int i = 0; i < OWNERS*FREQS; i++)
            m_buckets[i] = '0;
        owner_pool = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd1, 32'd2, 32'd3,
                       32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd77};

        directed.push_back('{32'd0, 32'd1000000, 64'd100, 64'd300, 1'b1,
            '{ST_OK, 8'd0, 6'd20, 64'd200, 40'd100, 32'd0, 9'd1}});
        directed.push_back('{32'd0, 32'd1000000, 64'd500, 64'd500, 1'b1,
            '{ST_EMPTY, 8'd0, 6'd0, 64'd0, 40'd0, 32'd1, 9'd1}});
        directed.push_back('{32'd0, 32'd0, 64'd400, 64'd600, 1'b1,
            '{ST_ZERO, 8'd0, 6'd0, 64'd0, 40'd0, 32'd2, 9'd1}});
        directed.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, {64{1'b1}}, 1'b1,
            '{ST_OK, 8'd1, 6'd63, {64{1'b1}}, 40'd0, 32'd0, 9'd2}});
        directed.push_back('{32'd0, 32'd1, 64'd350, 64'd360, 1'b1,
            '{ST_OK, 8'd0, 6'd1, 64'd10, 40'd50, 32'd2, 9'd2}});
        directed.push_back('{32'd0, 32'd24999, 64'd200, 64'd250, 1'b1,
            '{ST_OOO, 8'd0, 6'd1, 64'd60, 40'd0, 32'd3, 9'd2}});
        directed.push_back('{32'hFFFF_FFFF, 32'd1000, {64{1'b1}}, 64'd0, 1'b1,
            '{ST_EMPTY, 8'd1, 6'd0, 64'd0, 40'd0, 32'd1, 9'd2}});
        directed.push_back('{32'd5, 32'd3175000, 64'd0, 64'd1, 1'b0, none});
        directed.push_back('{32'd5, 32'd3124999, 64'd1, 64'd2, 1'b0, none});
        directed.push_back('{32'd5, 32'd75000, 64'd1000000002, 64'd1000000100, 1'b0, none});
        directed.push_back('{32'd5, 32'd74999, 64'd2000000099, 64'd2000000200, 1'b0, none});
        directed.push_back('{32'd5, 32'd25000, 64'd2000000201, 64'd2000000300, 1'b0, none});
        directed.push_back('{32'd0, 32'hFFFF_FFFF, 64'd1000, 64'h8000_0000_0000_0000,
            1'b0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            send_period(row.owner, row.freq, row.t_start, row.t_end, row.typed, row.want);
        end
        owner_clock[32'd0] = 64'h8000_0000_0000_0000;
        owner_clock[32'd5] = 64'd2000000300;
        owner_clock[32'hFFFF_FFFF] = {64{1'b1}};

        random_periods(150);
        drain_and_set_limit(40'd0);
        random_periods(150);
        drain_and_set_limit(40'd1000000000000);
        random_periods(150);
        drain_and_set_limit({8'd0, $urandom});
        random_periods(100);
        drain_and_set_limit(40'd5000);
        random_periods(100);
        quiet = 1'b1;
        random_periods(100);

        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
